// File: rtl/core/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types, constants and helper functions for the key debounce block
// with long-press detection and an event FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

   // Block sizing
   localparam int FIFO_DEPTH   = 16;
   localparam int FILTER_TICKS = 5;
   localparam int NUM_KEYS     = 6;
   localparam int KEY_SLOTS    = 6;

   localparam int FIFO_IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int KEY_IDX_W  = $clog2(KEY_SLOTS);
   localparam int FILT_W     = 4;
   localparam int HOLD_W     = 16;
   localparam int PHASE_W    = 2;
   localparam int CODE_W     = 5;
   localparam int PIN_W      = 4;

   localparam logic [FILT_W-1:0] FILT_MID   = FILT_W'(FILTER_TICKS);
   localparam logic [FILT_W-1:0] FILT_TOP   = FILT_W'(2 * FILTER_TICKS);
   localparam logic [FILT_W-1:0] FILT_RESET = FILT_W'(FILTER_TICKS / 2);

   // Key phases
   localparam logic [PHASE_W-1:0] PHASE_RELEASED = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_DOWN     = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_LONG     = 2'd3;

   // Event code offsets from 3 * key
   localparam logic [CODE_W-1:0] CODE_OFS_DOWN = 5'd1;
   localparam logic [CODE_W-1:0] CODE_OFS_UP   = 5'd2;
   localparam logic [CODE_W-1:0] CODE_OFS_LONG = 5'd3;
   localparam logic [CODE_W-1:0] CODE_NONE     = 5'd0;

   // Request functions
   localparam logic [1:0] FUNC_SCAN  = 2'd0;
   localparam logic [1:0] FUNC_POP   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_PIN_LEVELS = 3'd0;
   localparam logic [2:0] REG_LONG_TIME0 = 3'd1;
   localparam logic [2:0] REG_LONG_TIME_LAST = 3'(KEY_SLOTS);

   localparam logic [PIN_W-1:0]  PIN_LEVELS_RESET = 4'h1;
   localparam logic [HOLD_W-1:0] LONG_TIME_RESET  = 16'd100;

   typedef logic [KEY_SLOTS-1:0][HOLD_W-1:0] long_time_array_type;

   typedef struct packed {
      logic [FILT_W-1:0]  filter;
      logic [PHASE_W-1:0] phase;
      logic [HOLD_W-1:0]  hold;
   } key_state_type;

   localparam key_state_type KEY_STATE_RESET = '{
      filter: FILT_RESET, phase: PHASE_RELEASED, hold: '0};

   typedef struct packed {
      logic              push;
      logic [CODE_W-1:0] push_code;
      logic              pop;
      logic              clear;
   } fifo_ctl_type;

   typedef struct packed {
      logic              empty;
      logic [CODE_W-1:0] rdata;
   } fifo_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_PUSH2,
      ST_POP,
      ST_DONE
   } state_type;

   // Pressed-pin pattern of each virtual key (bit0 wakeup .. bit3 button2)
   function automatic logic [PIN_W-1:0] key_pattern(input logic [KEY_IDX_W-1:0] k);
      logic [PIN_W-1:0] pat;
      case (k)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h2;
         3'd2:    pat = 4'h4;
         3'd3:    pat = 4'h8;
         3'd4:    pat = 4'h3;
         3'd5:    pat = 4'h6;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

   // Base of a key's event codes: three codes per key
   function automatic logic [CODE_W-1:0] key_base(input logic [KEY_IDX_W-1:0] k);
      return CODE_W'({2'b00, k} + {1'b0, k, 1'b0});
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/kdlp_csr.sv
// ----------------------------------------------------------------------------
// kdlp_csr
// Register file behind the APB-style port: pin active levels and the
// long-press hold time of each key.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [kdlp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [kdlp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output logic      [kdlp_pkg::PIN_W-1:0]          pin_levels,
   output kdlp_pkg::long_time_array_type            long_time
);
   import kdlp_pkg::*;

   logic [PIN_W-1:0]    pin_levels_ff;
   long_time_array_type long_time_ff;
   logic [2:0]          reg_idx;
   logic [2:0]          long_idx;
   logic                wr_en;

   assign reg_idx  = csr_paddr[4:2];
   assign long_idx = 3'(reg_idx - REG_LONG_TIME0);
   assign wr_en    = csr_psel & csr_penable & csr_pwrite;

   assign csr_pready = 1'b1;
   assign pin_levels = pin_levels_ff;
   assign long_time  = long_time_ff;

   // Write on the access phase of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pin_levels_ff <= PIN_LEVELS_RESET;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            long_time_ff[i] <= LONG_TIME_RESET;
         end
      end else if (wr_en) begin
         if (reg_idx == REG_PIN_LEVELS) begin
            pin_levels_ff <= csr_pwdata[PIN_W-1:0];
         end else if (reg_idx inside {[REG_LONG_TIME0:REG_LONG_TIME_LAST]}) begin
            long_time_ff[long_idx] <= csr_pwdata[HOLD_W-1:0];
         end
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (reg_idx == REG_PIN_LEVELS) begin
         csr_prdata = CSR_DATA_W'(pin_levels_ff);
      end else if (reg_idx inside {[REG_LONG_TIME0:REG_LONG_TIME_LAST]}) begin
         csr_prdata = CSR_DATA_W'(long_time_ff[long_idx]);
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/kdlp_key_mem.sv
// ----------------------------------------------------------------------------
// kdlp_key_mem
// Per-key debounce state memory: one write port, one registered read port.
// Entries not yet written since reset read as the reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_key_mem (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [kdlp_pkg::KEY_IDX_W-1:0] raddr,
   output kdlp_pkg::key_state_type             rdata,
   input  wire logic                           wen,
   input  wire logic [kdlp_pkg::KEY_IDX_W-1:0] waddr,
   input  wire kdlp_pkg::key_state_type        wdata
);
   import kdlp_pkg::*;

   key_state_type        mem [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] valid_ff;
   key_state_type        rdata_ff;
   logic                 rvalid_ff;

   // Store write
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // Mark entries as written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wen) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rdata_ff  <= mem[raddr];
      rvalid_ff <= valid_ff[raddr];
   end

   assign rdata = rvalid_ff ? rdata_ff : KEY_STATE_RESET;

endmodule

`default_nettype wire

// File: rtl/core/kdlp_event_fifo.sv
// ----------------------------------------------------------------------------
// kdlp_event_fifo
// Wrapping event queue with no overflow check. The read data register
// always follows the entry at the read index.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_event_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire kdlp_pkg::fifo_ctl_type ctl,
   output kdlp_pkg::fifo_status_type  status
);
   import kdlp_pkg::*;

   localparam logic [FIFO_IDX_W-1:0] IDX_LAST = FIFO_IDX_W'(FIFO_DEPTH - 1);

   logic [CODE_W-1:0]     mem [FIFO_DEPTH];
   logic [FIFO_IDX_W-1:0] rd_idx_ff;
   logic [FIFO_IDX_W-1:0] wr_idx_ff;
   logic [CODE_W-1:0]     rdata_ff;

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_idx_ff] <= ctl.push_code;
      end
      rdata_ff <= mem[rd_idx_ff];
   end

   // Advance the indices
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
      end else begin
         if (ctl.push) begin
            wr_idx_ff <= (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
         end
         if (ctl.clear) begin
            rd_idx_ff <= wr_idx_ff;
         end else if (ctl.pop) begin
            rd_idx_ff <= (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + 1'b1;
         end
      end
   end

   assign status.empty = (rd_idx_ff == wr_idx_ff);
   assign status.rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/core/key_debounce_long_press_fifo.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_fifo
// Debounces four button pins decoded into six virtual keys, detects long
// presses and queues down, release and long events for the host to pop.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   func, wakeup/button0..2 pins
//   rsp      out        rsp_valid / rsp_stall   key_code
//   csr      in/out     APB-style, pready high  pin levels, long times
//
// A scan tick walks the keys through the key state memory, one key at a time,
// plus an extra step where the pressed key queues both its down and its long
// event, then loads the result. A pop passes a FIFO read state, then the result;
// clear and unknown functions go straight to the result.
// Synchronous reset; no clearing pass is needed. A stalled result holds the
// block in its final state; the next request is taken once that state leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_long_press_fifo (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_func,
   input  wire logic                            req_wakeup_pin,
   input  wire logic                            req_button0_pin,
   input  wire logic                            req_button1_pin,
   input  wire logic                            req_button2_pin,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [4:0]                           rsp_key_code,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [kdlp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [kdlp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [kdlp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import kdlp_pkg::*;

   localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(NUM_KEYS - 1);

   state_type state_ff, state_in;

   logic [KEY_IDX_W-1:0] key_idx_ff, key_idx_in;
   logic [PIN_W-1:0]     pressed_ff, pressed_in;
   logic [CODE_W-1:0]    res_code_ff, res_code_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;

   logic [PIN_W-1:0]    pin_levels;
   long_time_array_type long_time;

   logic [KEY_IDX_W-1:0] key_raddr;
   key_state_type        key_rd;
   key_state_type        key_wr;
   logic                 key_wen;

   fifo_ctl_type    fifo_ctl;
   fifo_status_type fifo_stat;

   logic              accept;
   logic              out_free;
   logic              is_last;
   logic              key_down;
   logic [HOLD_W-1:0] cur_long;
   logic [HOLD_W-1:0] hold_inc;
   logic              ev_down;
   logic              ev_long;
   logic              ev_up;
   logic              two_events;
   logic [CODE_W-1:0] base;
   logic [PIN_W-1:0]  pin_sample;

   kdlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pin_levels  (pin_levels),
      .long_time   (long_time)
   );

   kdlp_key_mem u_key_mem (
      .clock (clock),
      .reset (reset),
      .raddr (key_raddr),
      .rdata (key_rd),
      .wen   (key_wen),
      .waddr (key_idx_ff),
      .wdata (key_wr)
   );

   kdlp_event_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fifo_ctl),
      .status (fifo_stat)
   );

   // Handshake helpers
   assign accept     = req_valid & (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign is_last    = (key_idx_ff == KEY_LAST);
   assign pin_sample = {req_button2_pin, req_button1_pin, req_button0_pin, req_wakeup_pin};

   // Debounce and long-press update of the key being walked
   always_comb begin
      base     = key_base(key_idx_ff);
      key_down = (pressed_ff == key_pattern(key_idx_ff));
      cur_long = long_time[key_idx_ff];
      hold_inc = key_rd.hold + 1'b1;
      key_wr   = key_rd;
      ev_down  = 1'b0;
      ev_long  = 1'b0;
      ev_up    = 1'b0;
      if (key_down) begin
         if (key_rd.filter < FILT_MID) begin
            key_wr.filter = FILT_MID;
         end else if (key_rd.filter < FILT_TOP) begin
            key_wr.filter = key_rd.filter + 1'b1;
         end else begin
            if (key_rd.phase == PHASE_RELEASED) begin
               key_wr.phase = PHASE_DOWN;
               ev_down      = 1'b1;
            end
            if ((cur_long != '0) && (key_rd.hold < cur_long)) begin
               key_wr.hold = hold_inc;
               if (hold_inc == cur_long) begin
                  key_wr.phase = PHASE_LONG;
                  ev_long      = 1'b1;
               end
            end
         end
      end else begin
         if (key_rd.filter > FILT_MID) begin
            key_wr.filter = FILT_MID;
         end else if (key_rd.filter != '0) begin
            key_wr.filter = key_rd.filter - 1'b1;
         end else if ((key_rd.phase == PHASE_DOWN) || (key_rd.phase == PHASE_LONG)) begin
            key_wr.phase = PHASE_RELEASED;
            ev_up        = 1'b1;
         end
         key_wr.hold = '0;
      end
      two_events = ev_down & ev_long;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_SCAN: state_in = ST_CALC;
                  FUNC_POP:  state_in = ST_POP;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CALC: begin
            if (two_events)   state_in = ST_PUSH2;
            else if (is_last) state_in = ST_DONE;
         end
         ST_PUSH2: state_in = is_last ? ST_DONE : ST_CALC;
         ST_POP:   state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      key_idx_in         = key_idx_ff;
      pressed_in         = pressed_ff;
      res_code_in        = res_code_ff;
      key_raddr          = '0;
      key_wen            = 1'b0;
      fifo_ctl.push      = 1'b0;
      fifo_ctl.push_code = CODE_NONE;
      fifo_ctl.pop       = 1'b0;
      fifo_ctl.clear     = 1'b0;
      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      rsp_code_in        = rsp_code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_idx_in     = '0;
               pressed_in     = ~(pin_sample ^ pin_levels);
               res_code_in    = CODE_NONE;
               fifo_ctl.clear = (req_func == FUNC_CLEAR);
            end
         end
         ST_CALC: begin
            key_wen = 1'b1;
            if (ev_down)      fifo_ctl.push_code = base + CODE_OFS_DOWN;
            else if (ev_long) fifo_ctl.push_code = base + CODE_OFS_LONG;
            else              fifo_ctl.push_code = base + CODE_OFS_UP;
            fifo_ctl.push = ev_down | ev_long | ev_up;
            if (!two_events && !is_last) begin
               key_idx_in = key_idx_ff + 1'b1;
               key_raddr  = key_idx_ff + 1'b1;
            end
         end
         ST_PUSH2: begin
            fifo_ctl.push      = 1'b1;
            fifo_ctl.push_code = base + CODE_OFS_LONG;
            if (!is_last) begin
               key_idx_in = key_idx_ff + 1'b1;
               key_raddr  = key_idx_ff + 1'b1;
            end
         end
         ST_POP: begin
            fifo_ctl.pop = ~fifo_stat.empty;
            res_code_in  = fifo_stat.empty ? CODE_NONE : fifo_stat.rdata;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = res_code_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_idx_ff  <= key_idx_in;
      pressed_ff  <= pressed_in;
      res_code_ff <= res_code_in;
      rsp_code_ff <= rsp_code_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

endmodule

`default_nettype wire
